[src/imuc_pkg.sv]
// Shared types, constants and tables for the IMU raw-to-SI converter.
`timescale 1ns / 1ps
`default_nettype none

package imuc_pkg;

  // Sample and field widths
  localparam int SAMPLE_BITS   = 16;
  localparam int RAW_W         = 16;
  localparam int MODE_W        = 2;
  localparam int WHOLE_W       = 15;
  localparam int MICRO_W       = 21;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 40;

  // Configuration port
  localparam int ACCEL_SHIFT_W = 4;
  localparam int GYRO_SEL_W    = 2;
  localparam int CFG_ADDR_W    = 1;
  localparam int CFG_DATA_W    = 4;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_SHIFT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GYRO_SEL    = 1'd1;
  localparam logic [ACCEL_SHIFT_W-1:0] ACCEL_SHIFT_RST = 4'd11;
  localparam logic [GYRO_SEL_W-1:0]    GYRO_SEL_RST    = 2'd3;

  // Scaling datapath widths
  localparam int INT_K_W     = 24;
  localparam int FRAC_K_W    = 12;
  localparam int DIV_W       = 13;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 28;
  localparam int INT_PROD_W  = SAMPLE_BITS + INT_K_W;
  localparam int Y_W         = SAMPLE_BITS + FRAC_K_W;
  localparam int QE_W        = SAMPLE_BITS - 1;
  localparam int RP_W        = Y_W + RECIP_W;
  localparam int ACC_SUM_W   = INT_PROD_W + 1;
  localparam int MAGV_W      = 34;

  // Split by one million
  localparam int WHOLE_MAG_W = 14;
  localparam int MICRO_MAG_W = 20;
  localparam int SPLIT_RECIP_W = 15;
  localparam int SP_W        = MAGV_W + SPLIT_RECIP_W;
  localparam logic [SPLIT_RECIP_W-1:0] SPLIT_RECIP = 15'd17179;  // floor(2^34 / 1e6)
  localparam logic [MICRO_MAG_W-1:0]   ONE_MILLION = 20'd1000000;

  // Accelerometer: micro m/s^2 per LSB before shift, and saturation in micro units
  localparam logic [INT_K_W-1:0] ACCEL_K   = 24'd9806650;
  localparam logic [MAGV_W-1:0]  SAT_LIMIT = 34'd15855999999;

  // Temperature: raw * 1e8 / 207 split as integer plus fraction part
  localparam logic [INT_K_W-1:0]  TEMP_INT_K  = 24'd483091;
  localparam logic [FRAC_K_W-1:0] TEMP_FRAC_K = 12'd163;
  localparam logic [DIV_W-1:0]    TEMP_DIV    = 13'd207;
  localparam logic [RECIP_W-1:0]  TEMP_RECIP  = 21'd1296789;   // floor(2^28 / 207)
  localparam logic signed [WHOLE_W:0] TEMP_OFFSET = 16'sd25;

  // Gyroscope: pi*1e7 / (sens*180) reduced to num/den, split as integer plus fraction
  localparam logic [INT_K_W-1:0]  GYRO_INT_K  [4] = '{24'd133, 24'd266, 24'd532, 24'd1064};
  localparam logic [FRAC_K_W-1:0] GYRO_FRAC_K [4] = '{12'd1363, 12'd2726, 12'd83, 12'd83};
  localparam logic [DIV_W-1:0]    GYRO_DIV    [4] = '{13'd5895, 13'd5895, 13'd738, 13'd369};
  localparam logic [RECIP_W-1:0]  GYRO_RECIP  [4] =
    '{21'd45536, 21'd45536, 21'd363733, 21'd727467};

  typedef enum logic [MODE_W-1:0] {
    MODE_ACCEL = 2'd0,
    MODE_GYRO  = 2'd1,
    MODE_TEMP  = 2'd2,
    MODE_BAD   = 2'd3
  } mode_t;

  // Unsigned value in micro units with its sign
  typedef struct packed {
    mode_t             mode;
    logic              neg;
    logic [MAGV_W-1:0] magv;
  } imuc_mag_t;

  // Magnitude split into whole and millionths
  typedef struct packed {
    mode_t                  mode;
    logic                   neg;
    logic [WHOLE_MAG_W-1:0] whole_mag;
    logic [MICRO_MAG_W-1:0] micro_mag;
  } imuc_split_t;

  // Final signed result
  typedef struct packed {
    logic signed [WHOLE_W-1:0] whole;
    logic signed [MICRO_W-1:0] micro;
    logic                      bad;
  } imuc_result_t;

endpackage

`default_nettype wire

[src/imu_raw_to_si_converter.sv]
// Top level: IMU raw sample to SI units converter, configuration registers and streams.
//
//  channel   direction  transaction fields
//  s_axis    in         tuser: mode[1:0]; tdata: raw_sample[15:0]
//  m_axis    out        tuser: bad_mode; tdata: whole_part[14:0], micro_part[35:15]
//  cfg       in         cfg_wr_en, cfg_addr (0 accel_shift, 1 gyro_scale_select), cfg_wr_data
//
//  One sample per cycle sustained while m_axis_tready stays high;
//  9 register stages (5 scaling stages, 3 split stages by one million, 1 output register).
//  Synchronous reset empties the pipeline and loads accel_shift=11, gyro_scale_select=3.
//  Each stage holds under back-pressure and empty stages fill in, so stalls lose nothing.
`timescale 1ns / 1ps
`default_nettype none

module imu_raw_to_si_converter
  import imuc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] raw_sample
  input  wire logic [MODE_W-1:0]      s_axis_tuser,   // [1:0] mode
  // Output stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [14:0] whole_part, [35:15] micro_part
  output logic                        m_axis_tuser,   // [0] bad_mode
  // Configuration writes
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

  logic [ACCEL_SHIFT_W-1:0] accel_shift;
  logic [GYRO_SEL_W-1:0]    gyro_scale_select;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_shift       <= ACCEL_SHIFT_RST;
      gyro_scale_select <= GYRO_SEL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_ACCEL_SHIFT: accel_shift       <= cfg_wr_data[ACCEL_SHIFT_W-1:0];
        CFG_GYRO_SEL:    gyro_scale_select <= cfg_wr_data[GYRO_SEL_W-1:0];
      endcase
    end
  end

  // Pipeline
  logic         scl_valid;
  logic         scl_ready;
  imuc_mag_t    scl_data;
  logic         spl_valid;
  logic         spl_ready;
  imuc_split_t  spl_data;
  imuc_result_t res;

  imuc_scale u_scale (
    .clk               (clk),
    .rst               (rst),
    .accel_shift       (accel_shift),
    .gyro_scale_select (gyro_scale_select),
    .in_valid          (s_axis_tvalid),
    .in_ready          (s_axis_tready),
    .in_mode           (s_axis_tuser),
    .in_raw            (s_axis_tdata[RAW_W-1:0]),
    .out_valid         (scl_valid),
    .out_ready         (scl_ready),
    .out_data          (scl_data)
  );

  imuc_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scl_valid),
    .in_ready  (scl_ready),
    .in_data   (scl_data),
    .out_valid (spl_valid),
    .out_ready (spl_ready),
    .out_data  (spl_data)
  );

  imuc_format u_format (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (spl_valid),
    .in_ready  (spl_ready),
    .in_data   (spl_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - WHOLE_W - MICRO_W)'(0), res.micro, res.whole};
  assign m_axis_tuser = res.bad;

`ifndef SYNTHESIS
  a_bad_mode_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("bad mode result carries nonzero data");

  a_micro_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((res.micro < 21'sd1000000) && (res.micro > -21'sd1000000)))
    else $error("millionths out of range");

  a_whole_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((res.whole <= 15'sd15855) && (res.whole >= -15'sd15855)))
    else $error("whole part out of range");
`endif

endmodule

`default_nettype wire

[src/imuc_scale.sv]
// Five-stage scaling pipeline: sample to unsigned magnitude in micro units.
`timescale 1ns / 1ps
`default_nettype none

module imuc_scale
  import imuc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [ACCEL_SHIFT_W-1:0] accel_shift,
  input  wire logic [GYRO_SEL_W-1:0]    gyro_scale_select,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [MODE_W-1:0]        in_mode,
  input  wire logic [RAW_W-1:0]         in_raw,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output imuc_mag_t                     out_data
);

  localparam int NS = 5;

  logic [NS-1:0] v;
  logic [NS-1:0] ld;

  // Stage A: sign/magnitude and constant selection
  mode_t                  a_mode;
  logic                   a_neg;
  logic [SAMPLE_BITS-1:0] a_mag;
  logic [INT_K_W-1:0]     a_int_k;
  logic [FRAC_K_W-1:0]    a_frac_k;
  logic [DIV_W-1:0]       a_d;
  logic [RECIP_W-1:0]     a_m;
  // Stage B: products
  mode_t                  b_mode;
  logic                   b_neg;
  logic [INT_PROD_W-1:0]  b_int;
  logic [Y_W-1:0]         b_y;
  logic [DIV_W-1:0]       b_d;
  logic [RECIP_W-1:0]     b_m;
  // Stage C: quotient estimate, accel shift
  mode_t                  c_mode;
  logic                   c_neg;
  logic [INT_PROD_W-1:0]  c_int;
  logic [Y_W-1:0]         c_y;
  logic [DIV_W-1:0]       c_d;
  logic [QE_W-1:0]        c_qe;
  // Stage D: back-multiply, accel clamp
  mode_t                  d_mode;
  logic                   d_neg;
  logic [MAGV_W-1:0]      d_int;
  logic [Y_W-1:0]         d_y;
  logic [DIV_W-1:0]       d_d;
  logic [QE_W-1:0]        d_qe;
  logic [Y_W-1:0]         d_qd;
  // Stage E: corrected sum
  mode_t                  e_mode;
  logic                   e_neg;
  logic [MAGV_W-1:0]      e_magv;

  // Ready chain: a stage loads when empty or when its content moves on
  always_comb begin
    ld[NS-1] = !v[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v[NS-1];
  assign out_data  = '{mode: e_mode, neg: e_neg, magv: e_magv};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage A logic
  logic [SAMPLE_BITS-1:0] raw_bits;
  logic                   raw_neg;
  logic [SAMPLE_BITS-1:0] raw_mag;
  mode_t                  mode_in;
  logic [INT_K_W-1:0]     sel_int_k;
  logic [FRAC_K_W-1:0]    sel_frac_k;
  logic [DIV_W-1:0]       sel_d;
  logic [RECIP_W-1:0]     sel_m;

  always_comb begin
    raw_bits = in_raw[SAMPLE_BITS-1:0];
    raw_neg  = raw_bits[SAMPLE_BITS-1];
    raw_mag  = raw_neg ? SAMPLE_BITS'(~raw_bits + 1'b1) : raw_bits;
    mode_in  = mode_t'(in_mode);
    unique case (mode_in)
      MODE_GYRO: begin
        sel_int_k  = GYRO_INT_K[gyro_scale_select];
        sel_frac_k = GYRO_FRAC_K[gyro_scale_select];
        sel_d      = GYRO_DIV[gyro_scale_select];
        sel_m      = GYRO_RECIP[gyro_scale_select];
      end
      MODE_TEMP: begin
        sel_int_k  = TEMP_INT_K;
        sel_frac_k = TEMP_FRAC_K;
        sel_d      = TEMP_DIV;
        sel_m      = TEMP_RECIP;
      end
      MODE_ACCEL, MODE_BAD: begin
        // no fraction term; divider sees zero
        sel_int_k  = ACCEL_K;
        sel_frac_k = '0;
        sel_d      = TEMP_DIV;
        sel_m      = TEMP_RECIP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      a_mode   <= mode_in;
      a_neg    <= raw_neg;
      a_mag    <= raw_mag;
      a_int_k  <= sel_int_k;
      a_frac_k <= sel_frac_k;
      a_d      <= sel_d;
      a_m      <= sel_m;
    end
  end

  // Stage B: integer and fraction products
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      b_mode <= a_mode;
      b_neg  <= a_neg;
      b_int  <= INT_PROD_W'(a_mag) * INT_PROD_W'(a_int_k);
      b_y    <= Y_W'(a_mag) * Y_W'(a_frac_k);
      b_d    <= a_d;
      b_m    <= a_m;
    end
  end

  // Stage C: reciprocal estimate of y/d; accel floor shift on magnitude (ceil if negative)
  logic [RP_W-1:0]      recip_prod;
  logic [ACC_SUM_W-1:0] round_add;
  logic [ACC_SUM_W-1:0] acc_sum;
  logic [ACC_SUM_W-1:0] acc_shifted;

  always_comb begin
    recip_prod  = RP_W'(b_y) * RP_W'(b_m);
    round_add   = b_neg ? ((ACC_SUM_W'(1) << accel_shift) - ACC_SUM_W'(1)) : '0;
    acc_sum     = ACC_SUM_W'(b_int) + round_add;
    acc_shifted = acc_sum >> accel_shift;
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      c_mode <= b_mode;
      c_neg  <= b_neg;
      c_int  <= (b_mode == MODE_ACCEL) ? acc_shifted[INT_PROD_W-1:0] : b_int;
      c_y    <= b_y;
      c_d    <= b_d;
      c_qe   <= recip_prod[RECIP_SHIFT +: QE_W];
    end
  end

  // Stage D: estimate times divisor; saturate accel
  logic sat_hit;
  assign sat_hit = (c_mode == MODE_ACCEL) && (c_int > INT_PROD_W'(SAT_LIMIT));

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      d_mode <= c_mode;
      d_neg  <= c_neg;
      d_int  <= sat_hit ? SAT_LIMIT : c_int[MAGV_W-1:0];
      d_y    <= c_y;
      d_d    <= c_d;
      d_qe   <= c_qe;
      d_qd   <= Y_W'(c_qe) * Y_W'(c_d);
    end
  end

  // Stage E: estimate is exact or one low; fix and add integer term
  logic [Y_W-1:0]  rem_e;
  logic            corr;
  logic [QE_W-1:0] q_fix;

  always_comb begin
    rem_e = d_y - d_qd;
    corr  = rem_e >= Y_W'(d_d);
    q_fix = d_qe + QE_W'(corr);
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      e_mode <= d_mode;
      e_neg  <= d_neg;
      e_magv <= d_int + MAGV_W'(q_fix);
    end
  end

endmodule

`default_nettype wire

[src/imuc_split.sv]
// Three-stage split of a micro-unit magnitude into whole part and millionths.
`timescale 1ns / 1ps
`default_nettype none

module imuc_split
  import imuc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire imuc_mag_t in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output imuc_split_t out_data
);

  localparam int NS = 3;

  logic [NS-1:0] v;
  logic [NS-1:0] ld;

  mode_t                  f_mode;
  logic                   f_neg;
  logic [MAGV_W-1:0]      f_x;
  logic [WHOLE_MAG_W-1:0] f_qe;
  mode_t                  g_mode;
  logic                   g_neg;
  logic [MAGV_W-1:0]      g_x;
  logic [WHOLE_MAG_W-1:0] g_qe;
  logic [MAGV_W-1:0]      g_qd;
  mode_t                  h_mode;
  logic                   h_neg;
  logic [WHOLE_MAG_W-1:0] h_q;
  logic [MICRO_MAG_W-1:0] h_r;

  always_comb begin
    ld[NS-1] = !v[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v[NS-1];
  assign out_data  = '{mode: h_mode, neg: h_neg, whole_mag: h_q, micro_mag: h_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage F: quotient estimate by reciprocal of one million
  logic [SP_W-1:0] split_prod;
  assign split_prod = SP_W'(in_data.magv) * SP_W'(SPLIT_RECIP);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      f_mode <= in_data.mode;
      f_neg  <= in_data.neg;
      f_x    <= in_data.magv;
      f_qe   <= split_prod[MAGV_W +: WHOLE_MAG_W];
    end
  end

  // Stage G: back-multiply
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      g_mode <= f_mode;
      g_neg  <= f_neg;
      g_x    <= f_x;
      g_qe   <= f_qe;
      g_qd   <= MAGV_W'(f_qe) * MAGV_W'(ONE_MILLION);
    end
  end

  // Stage H: remainder with one correction step
  logic [MAGV_W-1:0] rem_h;
  logic              over;
  assign rem_h = g_x - g_qd;
  assign over  = rem_h >= MAGV_W'(ONE_MILLION);

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      h_mode <= g_mode;
      h_neg  <= g_neg;
      h_q    <= g_qe + WHOLE_MAG_W'(over);
      h_r    <= over ? MICRO_MAG_W'(rem_h - MAGV_W'(ONE_MILLION)) : rem_h[MICRO_MAG_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_rem_below_million: assert property (@(posedge clk) disable iff (rst)
    v[NS-1] |-> (h_r < ONE_MILLION))
    else $error("split remainder not below one million");
`endif

endmodule

`default_nettype wire

[src/imuc_format.sv]
// Output register stage: applies sign, temperature offset and borrow, bad mode.
`timescale 1ns / 1ps
`default_nettype none

module imuc_format
  import imuc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire imuc_split_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output imuc_result_t out_data
);

  logic         v;
  logic         ld;
  imuc_result_t res;

  assign ld        = !v || out_ready;
  assign in_ready  = ld;
  assign out_valid = v;
  assign out_data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (ld) begin
      v <= in_valid;
    end
  end

  // Signed parts; temperature borrows so millionths stay non-negative
  logic signed [WHOLE_W:0]   w_abs;
  logic signed [WHOLE_W:0]   w_sgn;
  logic signed [WHOLE_W:0]   w_temp;
  logic signed [MICRO_W-1:0] m_abs;
  logic signed [MICRO_W-1:0] m_sgn;
  logic signed [MICRO_W-1:0] m_temp;
  logic                      borrow;
  imuc_result_t              res_next;

  always_comb begin
    w_abs  = signed'({2'b00, in_data.whole_mag});
    m_abs  = signed'({1'b0, in_data.micro_mag});
    w_sgn  = in_data.neg ? -w_abs : w_abs;
    m_sgn  = in_data.neg ? -m_abs : m_abs;
    borrow = in_data.neg && (in_data.micro_mag != '0);
    w_temp = w_sgn + TEMP_OFFSET - (borrow ? 16'sd1 : 16'sd0);
    m_temp = borrow ? (signed'({1'b0, ONE_MILLION}) - m_abs) : m_abs;
    unique case (in_data.mode)
      MODE_ACCEL, MODE_GYRO: begin
        res_next = '{whole: w_sgn[WHOLE_W-1:0], micro: m_sgn, bad: 1'b0};
      end
      MODE_TEMP: begin
        res_next = '{whole: w_temp[WHOLE_W-1:0], micro: m_temp, bad: 1'b0};
      end
      MODE_BAD: begin
        res_next = '{whole: '0, micro: '0, bad: 1'b1};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_temp_micro_nonneg: assert property (@(posedge clk) disable iff (rst)
    (in_valid && ld && (in_data.mode == MODE_TEMP)) |=> (res.micro >= 0))
    else $error("temperature millionths negative");
`endif

endmodule

`default_nettype wire

[tb/si_result_checker.sv]
// Result checker for the raw-to-SI converter: predicts each result and compares field by field.
`timescale 1ns / 1ps

module si_result_checker
  import imuc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] raw_sample
  input  logic [MODE_W-1:0]      s_axis_tuser,   // [1:0] mode
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [14:0] whole_part, [35:15] micro_part
  input  logic                   m_axis_tuser,   // [0] bad_mode
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
  output int                     results_pending,
  output int                     mismatches
);

  // Scale factors in micro units
  localparam longint MICRO_PER_G   = 9806650;
  localparam longint MICRO_PI_X10  = 31415920;
  localparam longint MICRO         = 1000000;
  localparam longint ACCEL_CLAMP   = 64'sd15855999999;
  localparam longint DEG_PER_100   = 207;
  localparam longint TEMP_ZERO_DEG = 25;

  // One expected result with the sample that caused it
  typedef struct {
    mode_t                     mode;
    logic signed [RAW_W-1:0]   raw;
    imuc_result_t              res;
  } si_expect_t;

  logic [ACCEL_SHIFT_W-1:0] accel_shift_q;
  logic [GYRO_SEL_W-1:0]    gyro_sel_q;
  si_expect_t               expected_si[$];

  initial begin
    mismatches      = 0;
    results_pending = 0;
  end

  // Converts one raw sample to whole and millionths parts
  function automatic imuc_result_t convert_sample(mode_t mode, logic signed [RAW_W-1:0] raw,
                                                  logic [ACCEL_SHIFT_W-1:0] shift,
                                                  logic [GYRO_SEL_W-1:0] gsel);
    longint x, v, p, whole, micro, sens;
    imuc_result_t r;
    x     = raw;
    whole = 0;
    micro = 0;
    r.bad = 1'b0;
    case (mode)
      MODE_ACCEL: begin
        // arithmetic shift gives floor; clamp keeps the whole part in range
        v = (x * MICRO_PER_G) >>> shift;
        if (v > ACCEL_CLAMP) v = ACCEL_CLAMP;
        else if (v < -ACCEL_CLAMP) v = -ACCEL_CLAMP;
        whole = v / MICRO;
        micro = v % MICRO;
      end
      MODE_GYRO: begin
        case (gsel)
          2'd0:    sens = 1310;
          2'd1:    sens = 655;
          2'd2:    sens = 328;
          default: sens = 164;
        endcase
        v     = (x * MICRO_PI_X10) / (sens * 180);
        whole = v / MICRO;
        micro = v % MICRO;
      end
      MODE_TEMP: begin
        // fraction kept non-negative by borrowing from the whole part
        p     = x * 100;
        whole = p / DEG_PER_100 + TEMP_ZERO_DEG;
        micro = ((p % DEG_PER_100) * MICRO) / DEG_PER_100;
        if (micro < 0) begin
          whole = whole - 1;
          micro = micro + MICRO;
        end
      end
      default: r.bad = 1'b1;
    endcase
    r.whole = whole[WHOLE_W-1:0];
    r.micro = micro[MICRO_W-1:0];
    return r;
  endfunction

  // Prints one line per mismatch and counts every one
  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches = mismatches + 1;
  endtask

  // Track config, predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    si_expect_t   want;
    imuc_result_t got;
    if (rst) begin
      accel_shift_q <= ACCEL_SHIFT_RST;
      gyro_sel_q    <= GYRO_SEL_RST;
      expected_si.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_ACCEL_SHIFT: accel_shift_q <= cfg_wr_data[ACCEL_SHIFT_W-1:0];
          CFG_GYRO_SEL:    gyro_sel_q    <= cfg_wr_data[GYRO_SEL_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want.mode = mode_t'(s_axis_tuser);
        want.raw  = s_axis_tdata;
        want.res  = convert_sample(want.mode, want.raw, accel_shift_q, gyro_sel_q);
        expected_si.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.whole = m_axis_tdata[WHOLE_W-1:0];
        got.micro = m_axis_tdata[WHOLE_W +: MICRO_W];
        got.bad   = m_axis_tuser;
        if (expected_si.size() == 0) begin
          report_mismatch("output transaction with no result expected");
        end else begin
          want = expected_si.pop_front();
          if (got.whole !== want.res.whole)
            report_mismatch($sformatf("whole_part %0d, expected %0d (mode %s raw %0d)",
                                      got.whole, want.res.whole, want.mode.name(), want.raw));
          if (got.micro !== want.res.micro)
            report_mismatch($sformatf("micro_part %0d, expected %0d (mode %s raw %0d)",
                                      got.micro, want.res.micro, want.mode.name(), want.raw));
          if (got.bad !== want.res.bad)
            report_mismatch($sformatf("bad_mode %0b, expected %0b (mode %s raw %0d)",
                                      got.bad, want.res.bad, want.mode.name(), want.raw));
        end
      end
    end
    results_pending <= expected_si.size();
  end

endmodule

[tb/tb.sv]
// Testbench top for the raw-to-SI converter: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
  import imuc_pkg::*;

  localparam int IDLE_LIMIT  = 500;
  localparam int SETTLE      = 12;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASES      = 14;
  localparam int PER_PHASE   = 124;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [15:0] raw_sample
  logic [MODE_W-1:0]      s_axis_tuser;   // [1:0] mode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [14:0] whole_part, [35:15] micro_part
  logic                   m_axis_tuser;   // [0] bad_mode
  logic                   cfg_wr_en;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wr_data;

  int results_pending;
  int mismatches;
  int idle_cycles;
  bit no_idle;

  always #5 clk = ~clk;

  imu_raw_to_si_converter u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wr_data   (cfg_wr_data)
  );

  si_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_addr        (cfg_addr),
    .cfg_wr_data     (cfg_wr_data),
    .results_pending (results_pending),
    .mismatches      (mismatches)
  );

  // Wait before the next transaction; zero during no-idle stretches
  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(0, 10));
  endfunction

  // Offers one sample and returns at the falling edge after its transaction
  task automatic send_sample(mode_t mode, logic [RAW_W-1:0] raw);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    s_axis_tuser  <= mode;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Holds off input until every expected result has arrived, then lets the pipe settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Writes both registers; upper data bits of the gyro select are don't-care
  task automatic set_config(logic [ACCEL_SHIFT_W-1:0] shift, logic [GYRO_SEL_W-1:0] gsel);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= CFG_ACCEL_SHIFT;
    cfg_wr_data <= shift;
    @(negedge clk);
    cfg_addr    <= CFG_GYRO_SEL;
    cfg_wr_data <= {2'($urandom_range(0, 3)), gsel};
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
  endtask

  // Result side: random stall per result, then ready until a transaction
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  // Watchdog: ends the run after too long without any transaction
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and verdict
  initial begin
    logic [ACCEL_SHIFT_W-1:0] shift;
    logic [GYRO_SEL_W-1:0]    gsel;
    mode_t                    mode;
    logic [RAW_W-1:0]         raw;
    int                       pick;
    int                       t;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_wr_en     = 1'b0;
    cfg_addr      = '0;
    cfg_wr_data   = '0;
    idle_cycles   = 0;
    no_idle       = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes at reset config, temperature borrow, unsupported mode
    send_sample(MODE_ACCEL, 16'sd32767);
    send_sample(MODE_ACCEL, -16'sd32768);
    send_sample(MODE_ACCEL, 16'sd0);
    send_sample(MODE_ACCEL, 16'sd1);
    send_sample(MODE_ACCEL, -16'sd1);
    send_sample(MODE_GYRO,  16'sd32767);
    send_sample(MODE_GYRO,  -16'sd32768);
    send_sample(MODE_GYRO,  16'sd1);
    send_sample(MODE_GYRO,  -16'sd1);
    send_sample(MODE_TEMP,  16'sd32767);
    send_sample(MODE_TEMP,  -16'sd32768);
    send_sample(MODE_TEMP,  16'sd0);
    send_sample(MODE_TEMP,  -16'sd1);
    send_sample(MODE_TEMP,  -16'sd3);
    send_sample(MODE_TEMP,  16'sd1);
    send_sample(MODE_BAD,   16'hFFFF);
    send_sample(MODE_BAD,   16'h0000);

    // Random phases, each behind a fresh register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin shift = 4'd0;  gsel = 2'd0; end   // deep saturation
        1: begin shift = 4'd15; gsel = 2'd3; end
        2: begin shift = 4'd11; gsel = 2'd1; end
        3: begin shift = 4'd14; gsel = 2'd2; end
        4: begin shift = 4'd10; gsel = 2'd0; end   // just below normal range
        default: begin
          shift = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(11, 14))
                                             : 4'($urandom_range(0, 15));
          gsel  = 2'($urandom_range(0, 3));
        end
      endcase
      set_config(shift, gsel);
      no_idle = (ph % 4 == 3);

      for (int i = 0; i < PER_PHASE; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 6)       mode = MODE_ACCEL;
        else if (pick < 12) mode = MODE_GYRO;
        else if (pick < 18) mode = MODE_TEMP;
        else                mode = MODE_BAD;

        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          case ($urandom_range(0, 4))
            0:       raw = 16'h7FFF;
            1:       raw = 16'h8000;
            2:       raw = 16'h0000;
            3:       raw = 16'hFFFF;
            default: raw = 16'h0001;
          endcase
        end else if (pick < 3) begin
          // small magnitudes exercise sign handling of the fraction
          t   = int'($urandom_range(0, 600)) - 300;
          raw = t[RAW_W-1:0];
        end else begin
          raw = RAW_W'($urandom);
        end
        send_sample(mode, raw);
      end
    end

    // Wait for the last results, then let the pipeline run empty
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
